// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition");
`endif

// ===== hdl/twtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Timing wheel package
// Shared codes, types and constants.
// ----------------------------------------------------------------------------
package twtm_pkg;
  localparam int unsigned WheelSlotsDefault = 1024;
  localparam int unsigned TimerEntriesDefault = 16;
  localparam int unsigned TicksPerSecondDefault = 100;
  localparam int unsigned MsPerSecond = 1000;
  localparam int unsigned GenShift = 24;

  // interval_ms * ticks per second fits in ProdWidth bits for up to 1000 ticks
  localparam int unsigned ProdWidth = 26;
  localparam int unsigned RecipWidth = 27;
  localparam int unsigned DivShift = 36;
  localparam logic [RecipWidth-1:0] DivRecip =
    RecipWidth'(((64'd1 << DivShift) + 64'(MsPerSecond) - 64'd1) / 64'(MsPerSecond));

  localparam logic [1:0] ModeOff = 2'd0;
  localparam logic [1:0] ModeOnce = 2'd1;
  localparam logic [1:0] ModePeriodic = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_IDX = 3'd3,
    ST_STALE   = 3'd4,
    ST_INACTIVE = 3'd5
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] ticks;
    logic        periodic;
    logic [31:0] user_param;
    logic [31:0] timer_handle;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    status_e     status;
    logic [31:0] handle;
    logic [31:0] fired_param;
    logic        last;
  } res_t;
endpackage

// ===== hdl/timing_wheel_timer_manager.sv =====
// Timer manager on a hashed timing wheel. Items enter one at a time: full is
// high for the cycle after each transfer other than ACT_NONE while the
// interval is scaled to slots, and stays high while the two-entry command
// queue is full. A start or stop reply passes the stage-0 register and the
// command queue before the back end registers it on the result ports. A
// tick scans the timer table one entry per cycle while no fired timer waits
// on an unpopped result; the back end takes no command until the scan ends.
// ----------------------------------------------------------------------------
// Timing wheel timer manager
// Top level: front end, command queue and back end.
// ----------------------------------------------------------------------------
module timing_wheel_timer_manager #(
  parameter int unsigned WHEEL_SLOTS      = twtm_pkg::WheelSlotsDefault,
  parameter int unsigned TIMER_ENTRIES    = twtm_pkg::TimerEntriesDefault,
  parameter int unsigned TICKS_PER_SECOND = twtm_pkg::TicksPerSecondDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [15:0] interval_ms_i,
  input  logic        periodic_i,
  input  logic [31:0] user_param_i,
  input  logic [31:0] timer_handle_i,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [2:0]  status_o,
  output logic [31:0] handle_o,
  output logic [31:0] fired_param_o,
  output logic        last_o
);
  import twtm_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_take;

  twtm_front #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .action_i, .interval_ms_i,
    .periodic_i, .user_param_i, .timer_handle_i, .cmd_valid_o(cmd_valid),
    .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  twtm_back #(.WHEEL_SLOTS(WHEEL_SLOTS), .TIMER_ENTRIES(TIMER_ENTRIES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign result_kind_o = res.result_kind;
  assign status_o      = res.status;
  assign handle_o      = res.handle;
  assign fired_param_o = res.fired_param;
  assign last_o        = res.last;
endmodule

// ===== hdl/twtm_front.sv =====
// ----------------------------------------------------------------------------
// Timing wheel front end
// Accepts commands, converts intervals to slot counts, queues them.
// ----------------------------------------------------------------------------
module twtm_front #(
  parameter int unsigned TICKS_PER_SECOND = twtm_pkg::TicksPerSecondDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     action_i,
  input  logic [15:0]    interval_ms_i,
  input  logic           periodic_i,
  input  logic [31:0]    user_param_i,
  input  logic [31:0]    timer_handle_i,
  output logic           cmd_valid_o,
  input  logic           cmd_take_i,
  output twtm_pkg::cmd_t cmd_o
);
  import twtm_pkg::*;

  // stage 0: capture and multiply; stage 1: reciprocal divide; queue of 2
  logic                            s0_v_q;
  logic [1:0]                      s0_act_q;
  logic [ProdWidth-1:0]            s0_prod_q;
  logic                            s0_per_q;
  logic [31:0]                     s0_up_q, s0_th_q;
  cmd_t                            fifo_q [2];
  logic                            wr_q, rd_q;
  logic [1:0]                      cnt_q;
  logic                            s0_go;
  logic [ProdWidth+RecipWidth-1:0] quot;

  assign full_o = s0_v_q;
  assign s0_go = s0_v_q && (cnt_q != 2'd2);
  assign quot = (ProdWidth+RecipWidth)'(s0_prod_q) * (ProdWidth+RecipWidth)'(DivRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (push_i && !full_o && action_e'(action_i) != ACT_NONE) begin
      s0_v_q <= 1'b1;
    end else if (s0_go) begin
      s0_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      s0_act_q  <= action_i;
      s0_prod_q <= ProdWidth'(interval_ms_i) * ProdWidth'(TICKS_PER_SECOND);
      s0_per_q  <= periodic_i;
      s0_up_q   <= user_param_i;
      s0_th_q   <= timer_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (s0_go) wr_q <= ~wr_q;
      if (cmd_take_i && cnt_q != 2'd0) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(s0_go) - 2'(cmd_take_i && cnt_q != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_go) begin
      fifo_q[wr_q].action       <= action_e'(s0_act_q);
      fifo_q[wr_q].ticks        <= 32'(quot[ProdWidth+RecipWidth-1:DivShift]);
      fifo_q[wr_q].periodic     <= s0_per_q;
      fifo_q[wr_q].user_param   <= s0_up_q;
      fifo_q[wr_q].timer_handle <= s0_th_q;
    end
  end

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o = fifo_q[rd_q];
endmodule

// ===== hdl/twtm_back.sv =====
// ----------------------------------------------------------------------------
// Timing wheel back end
// Holds the timer table and free list, executes commands, scans on tick.
// ----------------------------------------------------------------------------
module twtm_back #(
  parameter int unsigned WHEEL_SLOTS   = twtm_pkg::WheelSlotsDefault,
  parameter int unsigned TIMER_ENTRIES = twtm_pkg::TimerEntriesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_take_o,
  input  twtm_pkg::cmd_t cmd_i,
  output logic           empty_o,
  input  logic           pop_i,
  output twtm_pkg::res_t res_o
);
  import twtm_pkg::*;

  localparam int unsigned SW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int unsigned IW = $clog2(TIMER_ENTRIES);
  localparam int unsigned CW = $clog2(TIMER_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [SW-1:0]            slot_q;
  logic [1:0]               mode_q [TIMER_ENTRIES];
  logic [7:0]               gen_q  [TIMER_ENTRIES];
  logic [SW-1:0]            due_q  [TIMER_ENTRIES];
  logic [SW-1:0]            per_q  [TIMER_ENTRIES];
  logic [31:0]              par_q  [TIMER_ENTRIES];
  logic [IW-1:0]            ff_q   [TIMER_ENTRIES];
  logic [IW-1:0]            head_q;
  logic [CW-1:0]            cnt_q;
  logic [IW-1:0]            scan_q;
  logic [TIMER_ENTRIES-1:0] hits_q;
  res_t                     out_q;
  logic                     out_v_q;

  logic                     out_free;
  logic                     take_tick, take_start, take_stop;
  logic                     start_ok, stop_ok;
  logic                     fire, fire_go, fire_last;
  logic                     scan_step, scan_done;
  logic                     load_res;
  res_t                     res_d;
  status_e                  cmd_status;
  logic [TIMER_ENTRIES-1:0] hits_d;
  logic [IW-1:0]            idx, newi, tail, head_next;
  logic [7:0]               hgen, newgen;
  logic [SW-1:0]            start_due, fire_due, slot_next;

  function automatic logic [IW-1:0] idx_add(logic [IW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(TIMER_ENTRIES)) s = s - (CW+1)'(TIMER_ENTRIES);
    return IW'(s);
  endfunction

  function automatic logic [SW-1:0] slot_add(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SW+1)'(WHEEL_SLOTS)) s = s - (SW+1)'(WHEEL_SLOTS);
    return s[SW-1:0];
  endfunction

  assign empty_o = !out_v_q;
  assign res_o   = out_q;
  assign out_free = !out_v_q || pop_i;

  assign cmd_take_o = state_q == S_IDLE && cmd_valid_i && out_free;
  assign take_tick  = cmd_take_o && cmd_i.action == ACT_TICK;
  assign take_start = cmd_take_o && cmd_i.action == ACT_START;
  assign take_stop  = cmd_take_o && cmd_i.action == ACT_STOP;

  assign idx       = cmd_i.timer_handle[IW-1:0];
  assign hgen      = cmd_i.timer_handle[31:24];
  assign newi      = ff_q[head_q];
  assign newgen    = gen_q[newi] + 8'd1;
  assign tail      = idx_add(head_q, cnt_q);
  assign head_next = idx_add(head_q, CW'(1));
  assign start_due = slot_add(slot_q, SW'(cmd_i.ticks));
  assign fire_due  = slot_add(slot_q, (per_q[scan_q] == '0) ? SW'(1) : per_q[scan_q]);
  assign slot_next = slot_add(slot_q, SW'(1));

  assign fire      = state_q == S_SCAN && hits_q[scan_q];
  assign fire_go   = fire && out_free;
  assign fire_last = ((hits_q >> scan_q) >> 1) == '0;
  assign scan_step = state_q == S_SCAN && (!fire || out_free);
  assign scan_done = scan_step && scan_q == IW'(TIMER_ENTRIES - 1);

  always_comb begin
    hits_d = '0;
    for (int i = 1; i < TIMER_ENTRIES; i++) begin
      hits_d[i] = mode_q[i] != ModeOff && due_q[i] == slot_q;
    end
  end

  always_comb begin
    cmd_status = ST_OK;
    start_ok   = 1'b0;
    stop_ok    = 1'b0;
    if (cmd_i.action == ACT_START) begin
      if (cnt_q == '0) begin
        cmd_status = ST_NO_FREE;
      end else if (cmd_i.ticks >= 32'(WHEEL_SLOTS)) begin
        cmd_status = ST_TOO_LONG;
      end else begin
        start_ok = 1'b1;
      end
    end else begin
      if (cmd_i.timer_handle[23:0] == 24'd0
          || cmd_i.timer_handle[23:0] >= 24'(TIMER_ENTRIES)) begin
        cmd_status = ST_BAD_IDX;
      end else if (gen_q[idx] != hgen) begin
        cmd_status = ST_STALE;
      end else if (mode_q[idx] == ModeOff) begin
        cmd_status = ST_INACTIVE;
      end else begin
        stop_ok = 1'b1;
      end
    end
  end

  always_comb begin
    load_res = 1'b0;
    res_d = '{1'b0, ST_OK, 32'd0, 32'd0, 1'b1};
    if (take_start || take_stop) begin
      load_res = 1'b1;
      res_d.status = cmd_status;
      if (start_ok) begin
        res_d.handle = {newgen, 24'(newi)};
      end else if (stop_ok) begin
        res_d.handle = cmd_i.timer_handle;
      end
    end else if (fire_go) begin
      load_res = 1'b1;
      res_d = '{1'b1, ST_OK, {gen_q[scan_q], 24'(scan_q)}, par_q[scan_q], fire_last};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (take_tick) state_d = S_SCAN;
      S_SCAN: if (scan_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      head_q  <= '0;
      cnt_q   <= CW'(TIMER_ENTRIES - 1);
      scan_q  <= '0;
      hits_q  <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < TIMER_ENTRIES; i++) begin
        mode_q[i] <= ModeOff;
        gen_q[i]  <= 8'd0;
        ff_q[i]   <= IW'((i + 1) % TIMER_ENTRIES);
      end
    end else begin
      state_q <= state_d;
      if (load_res) out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
      if (take_tick) begin
        hits_q <= hits_d;
        scan_q <= IW'(1);
      end else if (scan_step) begin
        scan_q <= scan_q + 1'b1;
      end
      if (scan_done) slot_q <= slot_next;
      if (take_start && start_ok) begin
        head_q       <= head_next;
        cnt_q        <= cnt_q - 1'b1;
        gen_q[newi]  <= newgen;
        mode_q[newi] <= cmd_i.periodic ? ModePeriodic : ModeOnce;
      end else if (take_stop && stop_ok) begin
        mode_q[idx] <= ModeOff;
        ff_q[tail]  <= idx;
        cnt_q       <= cnt_q + 1'b1;
      end else if (fire_go && mode_q[scan_q] != ModePeriodic) begin
        mode_q[scan_q] <= ModeOff;
        ff_q[tail]     <= scan_q;
        cnt_q          <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) out_q <= res_d;
    if (take_start && start_ok) begin
      par_q[newi] <= cmd_i.user_param;
      per_q[newi] <= SW'(cmd_i.ticks);
      due_q[newi] <= start_due;
    end else if (fire_go && mode_q[scan_q] == ModePeriodic) begin
      due_q[scan_q] <= fire_due;
    end
  end
endmodule

// ===== hdl/twtm_checker.sv =====
// ----------------------------------------------------------------------------
// Timing wheel port checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module twtm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        result_kind_o,
  input logic [2:0]  status_o,
  input logic [31:0] handle_o,
  input logic [31:0] fired_param_o,
  input logic        last_o
);
  import twtm_pkg::*;

  `ASSERT_NEVER(a_fire_ok, clk_i, rst_ni, !empty && result_kind_o && status_o != ST_OK)
  `ASSERT_NEVER(a_reply_last, clk_i, rst_ni, !empty && !result_kind_o && !last_o)
  `ASSERT_NEVER(a_fail_zero, clk_i, rst_ni, !empty && status_o != ST_OK && handle_o != 32'd0)
  `ASSERT_NEVER(a_reply_param, clk_i, rst_ni, !empty && !result_kind_o && fired_param_o != 0)
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, (!empty && !pop) |=> !empty)
endmodule

bind timing_wheel_timer_manager twtm_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .result_kind_o, .status_o, .handle_o,
  .fired_param_o, .last_o
);

// ===== tb/sv/timing_wheel_timer_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timing wheel timer manager testbench
// Drives start, stop, tick and no-op commands through the push/full queue, tracks
// the timer table in a local wheel model and checks every transfer on the
// empty/pop side in order, with random sender idle and receiver stall.
// ----------------------------------------------------------------------------
module timing_wheel_timer_manager_tb;
  import twtm_pkg::*;

  localparam int unsigned Slots = 1024;
  localparam int unsigned Entries = 16;
  localparam int unsigned Tps = 100;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RandomPerPhase = 108;

  typedef struct {
    logic        kind;
    status_e     status;
    logic [31:0] handle;
    logic [31:0] param;
    logic        last;
  } timer_result_t;

  typedef struct {
    action_e     act;
    logic [15:0] ms;
    logic        per;
    logic [31:0] prm;
    logic [31:0] hdl;
    bit          typed;
    status_e     t_status;
    logic [31:0] t_handle;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  action_i;
  logic [15:0] interval_ms_i;
  logic        periodic_i;
  logic [31:0] user_param_i;
  logic [31:0] timer_handle_i;
  logic        empty;
  logic        pop;
  logic        result_kind_o;
  logic [2:0]  status_o;
  logic [31:0] handle_o;
  logic [31:0] fired_param_o;
  logic        last_o;

  timing_wheel_timer_manager DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .interval_ms_i (interval_ms_i),
    .periodic_i    (periodic_i),
    .user_param_i  (user_param_i),
    .timer_handle_i(timer_handle_i),
    .empty         (empty),
    .pop           (pop),
    .result_kind_o (result_kind_o),
    .status_o      (status_o),
    .handle_o      (handle_o),
    .fired_param_o (fired_param_o),
    .last_o        (last_o)
  );

  // wheel model state
  logic [9:0]  cur_slot;
  logic [1:0]  ent_mode [Entries];
  logic [7:0]  ent_gen [Entries];
  logic [9:0]  ent_due [Entries];
  logic [9:0]  ent_period [Entries];
  logic [31:0] ent_param [Entries];
  logic [3:0]  free_list [Entries];
  logic [3:0]  free_head;
  logic [4:0]  free_count;

  timer_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic timer_result_t reply(status_e st, logic [31:0] h);
    timer_result_t r;
    r.kind = 1'b0;
    r.status = st;
    r.handle = h;
    r.param = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void wheel_reset();
    cur_slot = '0;
    for (int i = 0; i < Entries; i++) begin
      ent_mode[i] = ModeOff;
      ent_gen[i] = '0;
      ent_due[i] = '0;
      ent_period[i] = '0;
      ent_param[i] = '0;
      free_list[i] = (i + 1 < Entries) ? 4'(i + 1) : 4'd0;
    end
    free_head = '0;
    free_count = 5'(Entries - 1);
  endfunction

  function automatic void release_timer(int idx);
    ent_mode[idx] = ModeOff;
    ent_param[idx] = '0;
    if (free_count < Entries) begin
      free_list[4'(free_head + free_count)] = 4'(idx);
      free_count++;
    end
  endfunction

  function automatic void timer_wheel_predict(action_e act, logic [15:0] ms, logic per,
                                              logic [31:0] prm, logic [31:0] hdl);
    timer_result_t r;
    int unsigned   ticks;
    int unsigned   idx;
    int            n;
    case (act)
      ACT_TICK: begin
        n = 0;
        for (int i = 1; i < Entries; i++) begin
          if (ent_mode[i] != ModeOff && ent_due[i] == cur_slot) begin
            r.kind = 1'b1;
            r.status = ST_OK;
            r.handle = {ent_gen[i], 24'(i)};
            r.param = ent_param[i];
            r.last = 1'b0;
            pending_results.push_back(r);
            n++;
            if (ent_mode[i] == ModePeriodic) begin
              ent_due[i] = cur_slot + ((ent_period[i] != 0) ? ent_period[i] : 10'd1);
            end else begin
              release_timer(i);
            end
          end
        end
        if (n > 0) pending_results[$].last = 1'b1;
        cur_slot = cur_slot + 10'd1;
      end
      ACT_START: begin
        ticks = int'(ms) * Tps / MsPerSecond;
        if (free_count == 0) begin
          pending_results.push_back(reply(ST_NO_FREE, '0));
        end else if (ticks >= Slots) begin
          pending_results.push_back(reply(ST_TOO_LONG, '0));
        end else begin
          idx = free_list[free_head];
          free_head = free_head + 4'd1;
          free_count--;
          ent_gen[idx] = ent_gen[idx] + 8'd1;
          ent_mode[idx] = per ? ModePeriodic : ModeOnce;
          ent_param[idx] = prm;
          ent_period[idx] = 10'(ticks);
          ent_due[idx] = cur_slot + 10'(ticks);
          pending_results.push_back(reply(ST_OK, {ent_gen[idx], 24'(idx)}));
        end
      end
      ACT_STOP: begin
        idx = hdl[23:0];
        if (idx == 0 || idx >= Entries) begin
          pending_results.push_back(reply(ST_BAD_IDX, '0));
        end else if (ent_gen[idx] != hdl[31:24]) begin
          pending_results.push_back(reply(ST_STALE, '0));
        end else if (ent_mode[idx] == ModeOff) begin
          pending_results.push_back(reply(ST_INACTIVE, '0));
        end else begin
          release_timer(idx);
          pending_results.push_back(reply(ST_OK, hdl));
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(action_e act, logic [15:0] ms, logic per,
                              logic [31:0] prm, logic [31:0] hdl);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    action_i = act;
    interval_ms_i = ms;
    periodic_i = per;
    user_param_i = prm;
    timer_handle_i = hdl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    timer_wheel_predict(act, ms, per, prm, hdl);
  endtask

  // receiver: stall at random, check each transfer against the oldest expectation
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    timer_result_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d handle=%h param=%h last=%0d",
                 $time, result_kind_o, status_o, handle_o, fired_param_o, last_o);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_kind_o !== e.kind || status_o !== e.status || handle_o !== e.handle ||
            fired_param_o !== e.param || last_o !== e.last) begin
          $display("%0t: mismatch expected kind=%0d status=%0d handle=%h param=%h last=%0d",
                   $time, e.kind, e.status, e.handle, e.param, e.last);
          $display("%0t:          actual   kind=%0d status=%0d handle=%h param=%h last=%0d",
                   $time, result_kind_o, status_o, handle_o, fired_param_o, last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic stim_row_t row(action_e act, logic [15:0] ms, logic per, logic [31:0] prm,
                                    logic [31:0] hdl, bit typed = 0,
                                    status_e st = ST_OK, logic [31:0] th = '0);
    stim_row_t s;
    s.act = act;
    s.ms = ms;
    s.per = per;
    s.prm = prm;
    s.hdl = hdl;
    s.typed = typed;
    s.t_status = st;
    s.t_handle = th;
    return s;
  endfunction

  task automatic random_command();
    int unsigned roll;
    int unsigned pick;
    logic [15:0] ms;
    logic [31:0] hdl;
    int          live[$];
    roll = $urandom_range(99);
    if (roll < 40) begin
      send_command(ACT_TICK, 16'($urandom), 1'($urandom), $urandom, $urandom);
    end else if (roll < 75) begin
      pick = $urandom_range(99);
      if (pick < 70) ms = 16'($urandom_range(0, 300));
      else if (pick < 90) ms = 16'($urandom_range(0, 10239));
      else ms = 16'($urandom);
      send_command(ACT_START, ms, 1'($urandom), $urandom, $urandom);
    end else if (roll < 95) begin
      for (int i = 1; i < Entries; i++) if (ent_mode[i] != ModeOff) live.push_back(i);
      pick = $urandom_range(99);
      if (live.size() > 0 && pick < 80) begin
        hdl = {ent_gen[live[$urandom_range(live.size() - 1)]], 24'd0};
        hdl[23:0] = 24'(live[$urandom_range(live.size() - 1)]);
        hdl[31:24] = ent_gen[hdl[3:0]];
        if (pick >= 70) hdl[31:24] = hdl[31:24] - 8'd1;
      end else if (pick < 90) begin
        hdl = {8'($urandom), 24'($urandom_range(0, Entries))};
      end else begin
        hdl = $urandom;
      end
      send_command(ACT_STOP, 16'($urandom), 1'($urandom), $urandom, hdl);
    end else begin
      send_command(ACT_NONE, 16'($urandom), 1'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    stim_row_t   directed[$];
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle = '{0, 61, 0, 26};
    phase_stall = '{0, 0, 61, 26};
    push = 1'b0;
    action_i = ACT_TICK;
    interval_ms_i = '0;
    periodic_i = 1'b0;
    user_param_i = '0;
    timer_handle_i = '0;
    rst_ni = 1'b0;
    wheel_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed.push_back(row(ACT_START, 16'd0, 1'b0, 32'hFFFF_FFFF, '0, 1, ST_OK, 32'h0100_0001));
    directed.push_back(row(ACT_TICK, 16'hFFFF, 1'b1, '1, '1));
    directed.push_back(row(ACT_START, 16'd10230, 1'b1, '0, '0, 1, ST_OK, 32'h0100_0002));
    directed.push_back(row(ACT_START, 16'hFFFF, 1'b0, '0, '0, 1, ST_TOO_LONG, '0));
    directed.push_back(row(ACT_START, 16'd10240, 1'b1, '0, '0, 1, ST_TOO_LONG, '0));
    directed.push_back(row(ACT_START, 16'd0, 1'b1, 32'hA5A5_5A5A, '0, 1, ST_OK, 32'h0100_0003));
    directed.push_back(row(ACT_TICK, '0, 1'b0, '0, '0));
    directed.push_back(row(ACT_TICK, '0, 1'b0, '0, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0000_0000, 1, ST_BAD_IDX, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0000_0010, 1, ST_BAD_IDX, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'hFFFF_FFFF, 1, ST_BAD_IDX, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0200_0003, 1, ST_STALE, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0100_0001, 1, ST_INACTIVE, '0));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0100_0003, 1, ST_OK, 32'h0100_0003));
    directed.push_back(row(ACT_NONE, 16'hFFFF, 1'b1, '1, '1));
    directed.push_back(row(ACT_STOP, '0, 1'b0, '0, 32'h0100_0002, 1, ST_OK, 32'h0100_0002));
    directed.push_back(row(ACT_TICK, '0, 1'b0, '0, '0));

    foreach (directed[i]) begin
      send_command(directed[i].act, directed[i].ms, directed[i].per, directed[i].prm,
                   directed[i].hdl);
      if (directed[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(reply(directed[i].t_status, directed[i].t_handle));
      end
    end

    // exhaust the free list, then release every entry
    for (int i = 0; i < Entries; i++) begin
      send_command(ACT_START, 16'd5000, 1'(i), $urandom, '0);
    end
    for (int i = 1; i < Entries; i++) begin
      send_command(ACT_STOP, '0, 1'b0, '0, {ent_gen[i], 24'(i)});
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < RandomPerPhase; n++) random_command();
    end

    @(negedge clk_i);
    push = 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
